>>> src/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Fixed widths of the item fields
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = 16;
    localparam int COL_PORT_W = 7;
    localparam int ROW_PORT_W = 5;

    // Character and cell constants
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0220;
    localparam logic [CELL_W-1:0] CLEAR_CELL   = 16'h0000;
    localparam int                RESET_LINE   = 19;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT_CURSOR = 2'd0,
        OP_PUT_AT     = 2'd1,
        OP_READ       = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    // One command as accepted from the input side
    typedef struct packed {
        op_t                   operation;
        logic [CHAR_W-1:0]     char_code;
        logic [ATTR_W-1:0]     attribute;
        logic [COL_PORT_W-1:0] pos_col;
        logic [ROW_PORT_W-1:0] pos_row;
    } cmd_t;

    // One result handed to the output register
    typedef struct packed {
        logic [CELL_W-1:0]     cell_value;
        logic [COL_PORT_W-1:0] cursor_col;
        logic [ROW_PORT_W-1:0] cursor_row;
        logic                  scrolled;
    } res_t;

endpackage

>>> src/text_console_writer.sv
// Top level of the text console writer: stream ports and output register.
//
// A character console with a store of ROWS by COLUMNS cells (character in the low byte,
// attribute in the high byte) and a cursor. After reset the block clears every cell of the
// store and takes no item meanwhile. Items are handled one at a time: a read passes through
// the states EXEC, READ and RESP, an unused code goes straight to RESP, a put that does not
// scroll passes through EXEC and RESP, and a put that scrolls the screen also passes through
// SCROLL and DRAIN between them, since the scroll moves every cell through the single read
// and write port of the cell memory, one cell per cycle. The result sits in an output
// register, so the next item can be taken while it waits; only while that register still
// holds an earlier result that has not been taken does the block stall before finishing
// the current item.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], attribute[15:8], pos_col[22:16], pos_row[27:23]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cell_value[15:0], cursor_col[22:16], cursor_row[27:23], scrolled[28]
);

    cmd_t        cmd;
    res_t        res;
    logic        res_valid;
    logic        res_ready;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg,  m_tdata_next;

    // Unpack the input item
    assign cmd.operation = op_t'(s_tuser);
    assign cmd.char_code = s_tdata[7:0];
    assign cmd.attribute = s_tdata[15:8];
    assign cmd.pos_col   = s_tdata[22:16];
    assign cmd.pos_row   = s_tdata[27:23];

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: loads when empty or when its item is being taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_ready)
        begin
            m_tvalid_next = res_valid;
            if (res_valid)
            begin
                m_tdata_next = {3'b000, res.scrolled, res.cursor_row, res.cursor_col,
                                res.cell_value};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> src/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tcw_seq.sv
// Sequencer of the console: cursor, cell addressing, clearing and scrolling of the cell store.
module tcw_seq
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COLX_W    = (COL_W > COL_PORT_W) ? COL_W : COL_PORT_W;
    localparam int ROWX_W    = (ROW_W > ROW_PORT_W) ? ROW_W : ROW_PORT_W;
    localparam int RESET_ROW = (RESET_LINE < ROWS) ? RESET_LINE : (ROWS - 1);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_SCROLL = 7'b0010000,
        ST_DRAIN  = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    state_t              state_reg,   state_next;
    logic [ADDR_W-1:0]   scan_reg,    scan_next;
    op_t                 op_reg,      op_next;
    logic [CHAR_W-1:0]   ch_reg,      ch_next;
    logic [ATTR_W-1:0]   attr_reg,    attr_next;
    logic [COL_W-1:0]    col_reg,     col_next;
    logic [ROW_W-1:0]    row_reg,     row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [CELL_W-1:0]   value_reg,   value_next;
    logic                scr_reg,     scr_next;
    logic                wpend_reg,   wpend_next;
    logic [ADDR_W-1:0]   waddr_reg,   waddr_next;
    logic                wblank_reg,  wblank_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic [ADDR_W-1:0]   cell_addr;
    logic [ADDR_W-1:0]   src_addr;
    logic [COL_W-1:0]    pc_clamped;
    logic [ROW_W-1:0]    pr_clamped;
    logic                line_end;
    logic                row_last;
    logic [COL_W-1:0]    adv_col;
    logic [ROW_W-1:0]    adv_row;
    logic                adv_scroll;
    logic [COLX_W-1:0]   cur_col_ext;
    logic [ROWX_W-1:0]   cur_row_ext;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the requested position to the screen
    assign pc_clamped = (int'(cmd.pos_col) >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(cmd.pos_col);
    assign pr_clamped = (int'(cmd.pos_row) >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(cmd.pos_row);

    // Cell address of the working position and source address of a scroll copy
    assign cell_addr = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign src_addr  = ADDR_W'(int'(scan_reg) + COLUMNS);

    // Cursor advance after a put: newline or end of line moves to the next row
    assign line_end   = (ch_reg == NEWLINE_CODE) || (col_reg == COL_W'(COLUMNS - 1));
    assign row_last   = (row_reg == ROW_W'(ROWS - 1));
    assign adv_col    = line_end ? '0 : col_reg + 1'b1;
    assign adv_row    = (line_end && !row_last) ? row_reg + 1'b1 : row_reg;
    assign adv_scroll = line_end && row_last;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        op_next      = op_reg;
        ch_next      = ch_reg;
        attr_next    = attr_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        value_next   = value_reg;
        scr_next     = scr_reg;
        wpend_next   = 1'b0;
        waddr_next   = waddr_reg;
        wblank_next  = wblank_reg;
        cmd_ready    = 1'b0;
        res_valid    = 1'b0;
        ram_we       = wpend_reg;
        ram_waddr    = waddr_reg;
        ram_wdata    = wblank_reg ? BLANK_CELL : ram_rdata;
        ram_raddr    = cell_addr;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = CLEAR_CELL;
                if (int'(scan_reg) == CELLS - 1)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next    = cmd.operation;
                    ch_next    = cmd.char_code;
                    attr_next  = cmd.attribute;
                    value_next = '0;
                    scr_next   = 1'b0;
                    if (cmd.operation == OP_PUT_CURSOR)
                    begin
                        col_next = cur_col_reg;
                        row_next = cur_row_reg;
                    end
                    else
                    begin
                        col_next = pc_clamped;
                        row_next = pr_clamped;
                    end
                    state_next = (cmd.operation == OP_NONE) ? ST_RESP : ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                unique case (op_reg)
                    OP_READ:
                    begin
                        state_next = ST_READ;
                    end
                    OP_PUT_CURSOR, OP_PUT_AT:
                    begin
                        if (ch_reg != NEWLINE_CODE)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = cell_addr;
                            ram_wdata  = {attr_reg, ch_reg};
                            value_next = {attr_reg, ch_reg};
                        end
                        if (op_reg == OP_PUT_CURSOR)
                        begin
                            cur_col_next = adv_col;
                            cur_row_next = adv_row;
                        end
                        scr_next   = adv_scroll;
                        scan_next  = '0;
                        state_next = adv_scroll ? ST_SCROLL : ST_RESP;
                    end
                    OP_NONE:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_READ:
            begin
                value_next = ram_rdata;
                state_next = ST_RESP;
            end

            ST_SCROLL:
            begin
                // Read one line ahead; the write lands in the next cycle through the pending stage
                wpend_next = 1'b1;
                waddr_next = scan_reg;
                if (int'(scan_reg) < CELLS - COLUMNS)
                begin
                    ram_raddr   = src_addr;
                    wblank_next = 1'b0;
                end
                else
                begin
                    wblank_next = 1'b1;
                end
                if (int'(scan_reg) == CELLS - 1)
                begin
                    scan_next  = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            scan_reg    <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= ROW_W'(RESET_ROW);
            wpend_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            scan_reg    <= scan_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            wpend_reg   <= wpend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        attr_reg   <= attr_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        value_reg  <= value_next;
        scr_reg    <= scr_next;
        waddr_reg  <= waddr_next;
        wblank_reg <= wblank_next;
    end

    // Result as seen after the step
    assign cur_col_ext    = COLX_W'(cur_col_reg);
    assign cur_row_ext    = ROWX_W'(cur_row_reg);
    assign res.cell_value = value_reg;
    assign res.cursor_col = cur_col_ext[COL_PORT_W-1:0];
    assign res.cursor_row = cur_row_ext[ROW_PORT_W-1:0];
    assign res.scrolled   = scr_reg;

endmodule

>>> src/tcw_checker.sv
// Port-level checks of the text console writer and their binding to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Items are worked one at a time: no second item straight after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // An offered item holds until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input item changed while waiting");

    // The reported cursor column always lies on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[22:16]) < COLUMNS))
        else $error("cursor column off the screen");

    // The reported cursor row always lies on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[27:23]) < ROWS))
        else $error("cursor row off the screen");

    // A held result stays unchanged until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb.sv
// Self-checking testbench for the text console writer, with a scoreboard that tracks the screen.
`timescale 1ns / 100ps

module tb
    import tcw_pkg::*;
();

    localparam int SCR_COLS    = 80;
    localparam int SCR_ROWS    = 25;
    localparam int CELL_TOTAL  = SCR_COLS * SCR_ROWS;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL   = 60;
    localparam int DRAIN_WAIT  = 50;
    // Every item scrolling, each with the longest gap and stall, several times over.
    localparam int CYCLE_LIMIT = 3_000_000;

    // Keeps a shadow copy of the screen and cursor and the queue of expected results.
    class console_scoreboard;
        logic [CELL_W-1:0] cells [CELL_TOTAL];
        int                cur_col;
        int                cur_row;
        res_t              pending_q[$];
        int                fails;
        int                checked;
        int                puts;
        int                reads;
        int                nops;
        int                scrolls;

        function new();
            foreach (cells[i])
                cells[i] = CLEAR_CELL;
            cur_col = 0;
            cur_row = (RESET_LINE < SCR_ROWS) ? RESET_LINE : SCR_ROWS - 1;
        endfunction

        // Moves every line up by one and blanks the bottom line.
        function void shift_lines_up();
            for (int i = 0; i + SCR_COLS < CELL_TOTAL; i++)
                cells[i] = cells[i + SCR_COLS];
            for (int i = (SCR_ROWS - 1) * SCR_COLS; i < CELL_TOTAL; i++)
                cells[i] = BLANK_CELL;
        endfunction

        // Steps the row on, scrolling when already on the last line.
        function bit next_line(inout int row);
            if (row + 1 >= SCR_ROWS)
            begin
                row = SCR_ROWS - 1;
                shift_lines_up();
                return 1'b1;
            end
            row = row + 1;
            return 1'b0;
        endfunction

        // Writes one character at (col, row), unless it is a newline, and moves the position on.
        function logic [CELL_W-1:0] put_char(inout int col, inout int row,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic [ATTR_W-1:0] attr,
                                             output bit scr);
            logic [CELL_W-1:0] word;
            scr = 1'b0;
            if (ch == NEWLINE_CODE)
            begin
                col = 0;
                scr = next_line(row);
                return CLEAR_CELL;
            end
            word = {attr, ch};
            if (col >= SCR_COLS)
                col = SCR_COLS - 1;
            if (row >= SCR_ROWS)
                row = SCR_ROWS - 1;
            cells[row * SCR_COLS + col] = word;
            col = col + 1;
            if (col >= SCR_COLS)
            begin
                col = 0;
                scr = next_line(row);
            end
            return word;
        endfunction

        // Predicts the result of an accepted command and queues it.
        function void note_cmd(op_t op, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr,
                               logic [COL_PORT_W-1:0] pc, logic [ROW_PORT_W-1:0] pr);
            int                c;
            int                r;
            int                col;
            int                row;
            bit                scr;
            logic [CELL_W-1:0] val;
            res_t              want;
            c   = (pc >= SCR_COLS) ? SCR_COLS - 1 : int'(pc);
            r   = (pr >= SCR_ROWS) ? SCR_ROWS - 1 : int'(pr);
            val = CLEAR_CELL;
            scr = 1'b0;
            unique case (op)
                OP_PUT_CURSOR:
                begin
                    col = cur_col;
                    row = cur_row;
                    val = put_char(col, row, ch, attr, scr);
                    cur_col = col;
                    cur_row = row;
                    puts++;
                end
                OP_PUT_AT:
                begin
                    col = c;
                    row = r;
                    val = put_char(col, row, ch, attr, scr);
                    puts++;
                end
                OP_READ:
                begin
                    val = cells[r * SCR_COLS + c];
                    reads++;
                end
                default:
                    nops++;
            endcase
            if (scr)
                scrolls++;
            want.cell_value = val;
            want.cursor_col = COL_PORT_W'(cur_col);
            want.cursor_row = ROW_PORT_W'(cur_row);
            want.scrolled   = scr;
            pending_q.push_back(want);
        endfunction

        // Compares one delivered result with the oldest expectation.
        function void check_result(logic [31:0] data);
            res_t got;
            res_t want;
            got.cell_value = data[15:0];
            got.cursor_col = data[22:16];
            got.cursor_row = data[27:23];
            got.scrolled   = data[28];
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                fails++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.cell_value !== want.cell_value)
            begin
                $display("%0t: cell_value expected %h, actual %h",
                         $time, want.cell_value, got.cell_value);
                fails++;
            end
            if (got.cursor_col !== want.cursor_col)
            begin
                $display("%0t: cursor_col expected %0d, actual %0d",
                         $time, want.cursor_col, got.cursor_col);
                fails++;
            end
            if (got.cursor_row !== want.cursor_row)
            begin
                $display("%0t: cursor_row expected %0d, actual %0d",
                         $time, want.cursor_row, got.cursor_row);
                fails++;
            end
            if (got.scrolled !== want.scrolled)
            begin
                $display("%0t: scrolled expected %0b, actual %0b",
                         $time, want.scrolled, got.scrolled);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    console_scoreboard sb;
    bit                idle_on;
    int                sent;
    int                cycle_count;

    text_console_writer #(
        .COLUMNS(SCR_COLS),
        .ROWS   (SCR_ROWS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one command, with an occasional gap first, and waits until it is taken.
    task automatic send_cmd(op_t op, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr,
                            logic [COL_PORT_W-1:0] pc, logic [ROW_PORT_W-1:0] pr);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, pr, pc, attr, ch};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_cmd(op, ch, attr, pc, pr);
        sent++;
    endtask

    // Corners of the fields, every operation code, clamping, line ends and scrolls.
    task automatic directed_cmds();
        send_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd0);
        send_cmd(OP_READ, 8'hFF, 8'hFF, 7'd127, 5'd31);
        send_cmd(OP_PUT_CURSOR, 8'h00, 8'hFF, 7'd0, 5'd0);
        send_cmd(OP_PUT_CURSOR, 8'hFF, 8'h00, 7'd127, 5'd31);
        send_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd19);
        send_cmd(OP_NONE, 8'hFF, 8'hFF, 7'd127, 5'd31);
        // A positioned put at the end of a line, away from the bottom.
        send_cmd(OP_PUT_AT, 8'h5A, 8'h1E, 7'd79, 5'd10);
        // Clamped to the last cell of the screen, so the line end scrolls.
        send_cmd(OP_PUT_AT, 8'h51, 8'hA5, 7'd127, 5'd31);
        send_cmd(OP_READ, 8'h00, 8'h00, 7'd79, 5'd23);
        send_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd24);
        // Positioned newlines, one mid-screen and one on the last line.
        send_cmd(OP_PUT_AT, NEWLINE_CODE, 8'h33, 7'd5, 5'd3);
        send_cmd(OP_PUT_AT, NEWLINE_CODE, 8'h33, 7'd5, 5'd24);
        // Newlines at the cursor walk it to the bottom and then scroll.
        repeat (6)
            send_cmd(OP_PUT_CURSOR, NEWLINE_CODE, 8'h00, 7'd0, 5'd0);
        send_cmd(OP_PUT_CURSOR, 8'h41, 8'h07, 7'd64, 5'd16);
        send_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd24);
        send_cmd(OP_READ, 8'h00, 8'h00, 7'd0, 5'd23);
    endtask

    // Mostly runs of text at the cursor, mixed with positioned puts and reads.
    task automatic random_cmds();
        int                    done;
        int                    next_switch;
        int                    run_len;
        int                    pick;
        logic [CHAR_W-1:0]     ch;
        logic [COL_PORT_W-1:0] pc;
        logic [ROW_PORT_W-1:0] pr;
        done        = 0;
        next_switch = 0;
        while (done < RANDOM_ITEMS)
        begin
            // Idling comes and goes in stretches and stops for the tail of the run.
            if (done >= RANDOM_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            else if (done >= next_switch)
            begin
                idle_on     = ($urandom_range(0, 3) != 0);
                next_switch = done + 40;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                run_len = $urandom_range(1, 40);
                if (run_len > RANDOM_ITEMS - done)
                    run_len = RANDOM_ITEMS - done;
                repeat (run_len)
                begin
                    ch = ($urandom_range(0, 11) == 0) ? NEWLINE_CODE : 8'($urandom);
                    send_cmd(OP_PUT_CURSOR, ch, 8'($urandom), 7'($urandom), 5'($urandom));
                end
                done += run_len;
            end
            else if (pick < 65)
            begin
                ch = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom);
                pc = ($urandom_range(0, 5) == 0) ? 7'(SCR_COLS - 1) : 7'($urandom);
                send_cmd(OP_PUT_AT, ch, 8'($urandom), pc, 5'($urandom));
                done++;
            end
            else if (pick < 95)
            begin
                // Half of the reads look near the cursor, where the text lands.
                if ($urandom_range(0, 1) == 0)
                begin
                    pc = 7'($urandom_range(0, SCR_COLS - 1));
                    pr = 5'($urandom_range(15, SCR_ROWS - 1));
                end
                else
                begin
                    pc = 7'($urandom);
                    pr = 5'($urandom);
                end
                send_cmd(OP_READ, 8'($urandom), 8'($urandom), pc, pr);
                done++;
            end
            else
            begin
                send_cmd(OP_NONE, 8'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
                done++;
            end
        end
    endtask

    // Result side: checks each delivered item and stalls in random bursts.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 6) == 0)
            begin
                hold = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on the length of the run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d results outstanding",
                 $time, sb.pending_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence: reset, directed commands, random traffic, drain and verdict.
    initial
    begin
        sb      = new();
        idle_on = 1'b1;
        sent    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        directed_cmds();
        random_cmds();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Sent %0d commands: %0d puts, %0d reads, %0d unused codes.",
                 sent, sb.puts, sb.reads, sb.nops);
        $display("Checked %0d results, %0d of which scrolled the screen.",
                 sb.checked, sb.scrolls);
        if (sb.fails == 0 && sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
